// ===== hw/rtl/mdsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsl_pkg
// Shared types and constants of the motor duty slew limiter.
// ----------------------------------------------------------------------------
package mdsl_pkg;

	localparam int DutyW  = 8;
	localparam int CmdW   = 16;
	localparam int MotorW = 2;
	localparam int CfgIdxW = 1;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_SLEW_STEP = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_MAX_DUTY  = 1'b1;

	localparam logic [DutyW-1:0] SLEW_STEP_RST = 8'd4;
	localparam logic [DutyW-1:0] MAX_DUTY_RST  = 8'd255;

	typedef struct packed {
		logic             rev;
		logic [DutyW-1:0] duty;
	} drive_state_t;

	typedef struct packed {
		logic [DutyW-1:0] slew_step;
		logic [DutyW-1:0] max_duty;
	} slew_cfg_t;

endpackage

// ===== hw/rtl/mdsl_if.sv =====
// ----------------------------------------------------------------------------
// mdsl_if
// Valid/ready channels for command words and drive words.
// ----------------------------------------------------------------------------
interface mdsl_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [mdsl_pkg::MotorW-1:0]       motor_id;
	logic signed [mdsl_pkg::CmdW-1:0]  target_command;
	logic                              stop_all;

	modport source (output valid, output motor_id, output target_command,
		output stop_all, input ready);
	modport sink (input valid, input motor_id, input target_command,
		input stop_all, output ready);
endinterface

interface mdsl_drive_if;
	logic                         valid;
	logic                         ready;
	logic [mdsl_pkg::MotorW-1:0]  out_motor;
	logic                         drive_reverse;
	logic [mdsl_pkg::DutyW-1:0]   drive_duty;

	modport source (output valid, output out_motor, output drive_reverse,
		output drive_duty, input ready);
	modport sink (input valid, input out_motor, input drive_reverse,
		input drive_duty, output ready);
endinterface

// ===== hw/rtl/mdsl_slew.sv =====
// ----------------------------------------------------------------------------
// mdsl_slew
// Next drive state of one motor: command saturation and slew limiting.
// ----------------------------------------------------------------------------
module mdsl_slew (
	input  logic [mdsl_pkg::CmdW-1:0] target_command,
	input  mdsl_pkg::drive_state_t    cur,
	input  mdsl_pkg::slew_cfg_t       cfg,
	output mdsl_pkg::drive_state_t    nxt
);

	logic                          neg;
	logic [mdsl_pkg::CmdW:0]       mag;
	logic [mdsl_pkg::DutyW-1:0]    tduty;
	logic                          tdir;
	logic [mdsl_pkg::DutyW-1:0]    dn;
	logic [mdsl_pkg::DutyW-1:0]    dn_clamp;
	logic [mdsl_pkg::DutyW:0]      up;
	logic [mdsl_pkg::DutyW-1:0]    up_clamp;

	// magnitude of the command, -32768 included
	assign neg = target_command[mdsl_pkg::CmdW-1];
	assign mag = neg ? ((mdsl_pkg::CmdW+1)'(1) << mdsl_pkg::CmdW) - {1'b0, target_command}
		: {1'b0, target_command};

	assign tduty = (mag > (mdsl_pkg::CmdW+1)'(cfg.max_duty)) ? cfg.max_duty
		: mag[mdsl_pkg::DutyW-1:0];
	assign tdir  = neg && (tduty != '0);

	assign dn       = (cur.duty > cfg.slew_step) ? cur.duty - cfg.slew_step : '0;
	assign dn_clamp = (dn > cfg.max_duty) ? cfg.max_duty : dn;
	assign up       = {1'b0, cur.duty} + {1'b0, cfg.slew_step};
	assign up_clamp = (up > {1'b0, cfg.max_duty}) ? cfg.max_duty : up[mdsl_pkg::DutyW-1:0];

	always_comb begin
		nxt = cur;
		priority if (tdir != cur.rev) begin
			nxt.duty = dn;
			// direction flips only once the duty has reached zero
			if (dn == '0) begin
				nxt.rev = tdir;
			end
		end else if (cur.duty > tduty) begin
			nxt.duty = (dn_clamp < tduty) ? tduty : dn_clamp;
		end else if (cur.duty < tduty) begin
			nxt.duty = (up_clamp > tduty) ? tduty : up_clamp;
		end else begin
			nxt = cur;
		end
	end

endmodule

// ===== hw/rtl/motor_duty_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// motor_duty_slew_limiter
// Slew limited direction and duty per motor channel.
//
//   channel  dir  word
//   cmd      in   motor_id, target_command, stop_all
//   drive    out  out_motor, drive_reverse, drive_duty
//   cfg_*    in   register write: slew_step (0), max_duty (1)
//
// One word per cycle while the drive word is not stalled; a command word passes
// through the input register and then the result register before it is
// presented as a drive word.
// The per-motor state is flip-flops, written as a word moves into the result
// register, so the next word reads the updated value without forwarding.
// A stalled drive word holds the input register; cmd.ready then follows
// drive.ready. arst_n clears the per-motor state and the valid flags and sets
// the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module motor_duty_slew_limiter #(
	parameter int MOTORS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mdsl_cmd_if.sink                          cmd,
	mdsl_drive_if.source                      drive,
	input  logic                              cfg_we,
	input  logic [mdsl_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [mdsl_pkg::DutyW-1:0]        cfg_data
);

	localparam int IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int ExtW = (IdxW > mdsl_pkg::MotorW) ? IdxW : mdsl_pkg::MotorW;

	mdsl_pkg::slew_cfg_t cfg_q;

	logic                              valid_s1;
	logic [mdsl_pkg::MotorW-1:0]       motor_s1;
	logic [mdsl_pkg::CmdW-1:0]         command_s1;
	logic                              stop_s1;

	logic                              out_valid_q;
	logic [mdsl_pkg::MotorW-1:0]       out_motor_q;
	logic                              out_rev_q;
	logic [mdsl_pkg::DutyW-1:0]        out_duty_q;

	logic                              rev_q  [MOTORS];
	logic [mdsl_pkg::DutyW-1:0]        duty_q [MOTORS];

	logic                              adv;
	logic [ExtW-1:0]                   motor_ext;
	logic [IdxW-1:0]                   idx;
	logic                              in_range;
	mdsl_pkg::drive_state_t            cur;
	mdsl_pkg::drive_state_t            nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_step <= mdsl_pkg::SLEW_STEP_RST;
			cfg_q.max_duty  <= mdsl_pkg::MAX_DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mdsl_pkg::REG_SLEW_STEP: cfg_q.slew_step <= cfg_data;
				mdsl_pkg::REG_MAX_DUTY:  cfg_q.max_duty  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = valid_s1 && (!out_valid_q || drive.ready);
	assign cmd.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			motor_s1   <= cmd.motor_id;
			command_s1 <= cmd.target_command;
			stop_s1    <= cmd.stop_all;
		end
	end

	assign motor_ext = ExtW'(motor_s1);
	assign idx       = motor_ext[IdxW-1:0];
	assign in_range  = (32'(motor_s1) < 32'(MOTORS));

	always_comb begin
		cur = '0;
		if (in_range) begin
			cur.rev  = rev_q[idx];
			cur.duty = duty_q[idx];
		end
	end

	mdsl_slew u_slew (
		.target_command (command_s1),
		.cur            (cur),
		.cfg            (cfg_q),
		.nxt            (nxt)
	);

	// per-motor state, written as the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTORS; i++) begin
				rev_q[i]  <= 1'b0;
				duty_q[i] <= '0;
			end
		end else if (adv && in_range) begin
			for (int i = 0; i < MOTORS; i++) begin
				if (idx == IdxW'(i)) begin
					if (stop_s1) begin
						duty_q[i] <= '0;
					end else begin
						rev_q[i]  <= nxt.rev;
						duty_q[i] <= nxt.duty;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_motor_q <= motor_s1;
			if (stop_s1 || !in_range) begin
				out_rev_q  <= 1'b0;
				out_duty_q <= '0;
			end else begin
				out_rev_q  <= nxt.rev;
				out_duty_q <= nxt.duty;
			end
		end
	end

	assign drive.valid         = out_valid_q;
	assign drive.out_motor     = out_motor_q;
	assign drive.drive_reverse = out_rev_q;
	assign drive.drive_duty    = out_duty_q;

`ifndef SYNTH
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (stop_s1 || !in_range) |=> !drive.drive_reverse && drive.drive_duty == '0)
		else $error("stopped or unknown motor gave nonzero drive");

	a_flip_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_range && !stop_s1 && nxt.rev != cur.rev |-> nxt.duty == '0)
		else $error("direction changed at nonzero duty");

	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && out_valid_q && !drive.ready)
		else $error("command stalled without a blocked drive word");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> drive.valid && drive.out_motor == $past(motor_s1))
		else $error("drive word lost or motor index changed");
`endif

endmodule
